// ===== rtl/fss_pkg.sv =====
// shared types, constants and the speed curve table of the four step sequencer
package fss_pkg;

    localparam int LEVEL_W = 10;
    localparam int TICK_W  = 16;

    typedef enum logic {
        OP_PWM  = 1'b0,
        OP_TICK = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        REG_STEP_ONE   = 3'd0,
        REG_STEP_TWO   = 3'd1,
        REG_STEP_THREE = 3'd2,
        REG_STEP_FOUR  = 3'd3,
        REG_SPEED      = 3'd4
    } t_reg_idx;

    localparam logic [9:0]  RISE_LEVEL    = 10'h200;
    localparam logic [9:0]  FALL_LEVEL    = 10'h1E0;
    localparam logic [9:0]  SAMPLE_FLOOR  = 10'd15;
    localparam logic [9:0]  RUN_LEVEL     = 10'd40;
    localparam logic [15:0] GATE_MIN_OFF  = 16'd600;
    localparam logic [15:0] GATE_MIN_ON   = 16'd36;
    localparam logic [9:0]  KNOB_MAX      = 10'h3FF;
    localparam logic [4:0]  PERIOD_SCALE  = 5'd23;
    localparam logic [1:0]  DEBOUNCE_TICKS = 2'd3;
    // cycles for the speed curve registers to follow a speed knob write
    localparam logic [1:0]  SPEED_SETTLE  = 2'd3;

    typedef struct packed {
        logic       opcode;
        logic       sample_valid;
        logic [9:0] sample;
        logic       mode_switch_external;
    } t_req;

    typedef struct packed {
        logic [9:0] duty_out;
        logic [1:0] active_step;
        logic       trigger_out;
        logic       external_mode;
    } t_rsp;

    function automatic logic [15:0] speed_curve(input logic [4:0] idx);
        logic [15:0] val;
        case (idx)
            5'd0:    val = 16'd36000;
            5'd1:    val = 16'd18000;
            5'd2:    val = 16'd12000;
            5'd3:    val = 16'd9600;
            5'd4:    val = 16'd8000;
            5'd5:    val = 16'd6857;
            5'd6:    val = 16'd6000;
            5'd7:    val = 16'd5143;
            5'd8:    val = 16'd4500;
            5'd9:    val = 16'd4000;
            5'd10:   val = 16'd3600;
            5'd11:   val = 16'd3273;
            5'd12:   val = 16'd3000;
            5'd13:   val = 16'd2250;
            5'd14:   val = 16'd1500;
            5'd15:   val = 16'd1000;
            5'd16:   val = 16'd581;
            default: val = 16'd581;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/fss_if.sv =====
// valid/ready channel interfaces for requests and results
interface fss_req_if;
    logic          valid;
    logic          ready;
    fss_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fss_rsp_if;
    logic          valid;
    logic          ready;
    fss_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/four_step_sequencer.sv =====
// four step sequencer: request register, single pass step logic, result register
//
// channel   dir  handshake          payload
// i_req     in   valid/ready        opcode, sample_valid, sample, mode_switch_external
// o_rsp     out  valid/ready        duty_out, active_step, trigger_out, external_mode
// apb       in   psel/penable/...   step levels 0..3, speed knob at 4 (byte addr 4*i)
//
// one request per cycle sustained while results are taken and the speed curve has settled;
// a result is valid once the step logic has loaded the result register straight from the request register
// the speed curve is a three stage pipeline off the speed knob register; after
// reset or a speed knob write no request is taken until the settle count has run out
// a stalled result holds in the result register while one more request waits
// in the request register
module four_step_sequencer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fss_req_if.sink      i_req,
    fss_rsp_if.source    o_rsp,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // configuration
    logic [9:0]  r_step_level [4];
    logic [9:0]  r_speed_knob;
    logic [1:0]  r_settle;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    // speed curve pipeline
    logic [9:0]  knob_rev;
    logic [4:0]  curve_idx;
    logic [5:0]  curve_frac;
    logic [25:0] r_prod_a;
    logic [21:0] r_prod_b;
    logic [26:0] curve_sum;
    logic [20:0] period_scaled;
    logic [15:0] r_period;
    logic [15:0] gate_off;
    logic [15:0] gate_quarter;
    logic [15:0] r_gate_hi;

    // channel registers
    logic          r_in_valid;
    fss_pkg::t_req r_in;
    logic          r_out_valid;
    fss_pkg::t_rsp r_out;
    fss_pkg::t_rsp n_out;
    logic          move;

    // sequencer state
    logic [1:0]  r_step_index,   n_step_index;
    logic [9:0]  r_level_now,    n_level_now;
    logic        r_gate_open,    n_gate_open;
    logic [15:0] r_tick_count,   n_tick_count;
    logic [9:0]  r_held_input,   n_held_input;
    logic        r_input_was_low, n_input_was_low;
    logic        r_rise_pending, n_rise_pending;
    logic        r_fall_pending, n_fall_pending;
    logic        r_mode_external, n_mode_external;
    logic [1:0]  r_to_int_count, n_to_int_count;
    logic [1:0]  r_to_ext_count, n_to_ext_count;
    logic        r_trigger,      n_trigger;

    logic [19:0] level_prod;
    logic [9:0]  sample_clean;
    logic [15:0] tick_base;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_step_level[k] <= '0;
            end
            r_speed_knob <= '0;
            r_settle     <= fss_pkg::SPEED_SETTLE;
        end else begin
            if (cfg_wr && cfg_idx < 3'(fss_pkg::REG_SPEED)) begin
                r_step_level[cfg_idx[1:0]] <= pwdata[9:0];
            end
            if (cfg_wr && cfg_idx == 3'(fss_pkg::REG_SPEED)) begin
                r_speed_knob <= pwdata[9:0];
                r_settle     <= fss_pkg::SPEED_SETTLE;
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            3'(fss_pkg::REG_STEP_ONE):   prdata = {22'd0, r_step_level[0]};
            3'(fss_pkg::REG_STEP_TWO):   prdata = {22'd0, r_step_level[1]};
            3'(fss_pkg::REG_STEP_THREE): prdata = {22'd0, r_step_level[2]};
            3'(fss_pkg::REG_STEP_FOUR):  prdata = {22'd0, r_step_level[3]};
            3'(fss_pkg::REG_SPEED):      prdata = {22'd0, r_speed_knob};
            default:                     prdata = '0;
        endcase
    end

    // ---------------- speed curve ----------------
    assign knob_rev   = fss_pkg::KNOB_MAX - r_speed_knob;
    assign curve_idx  = {1'b0, knob_rev[9:6]};
    assign curve_frac = knob_rev[5:0];

    // interpolation between neighboring curve points
    always_ff @(posedge i_clk) begin
        r_prod_a <= fss_pkg::speed_curve(curve_idx)
                    * (fss_pkg::KNOB_MAX - {4'd0, curve_frac});
        r_prod_b <= fss_pkg::speed_curve(curve_idx + 5'd1) * curve_frac;
    end

    assign curve_sum     = {1'b0, r_prod_a} + {5'd0, r_prod_b};
    assign period_scaled = curve_sum[25:10] * fss_pkg::PERIOD_SCALE;

    always_ff @(posedge i_clk) begin
        r_period <= period_scaled[20:5];
    end

    assign gate_quarter = {2'd0, r_period[15:2]};
    assign gate_off     = (gate_quarter < fss_pkg::GATE_MIN_OFF) ? fss_pkg::GATE_MIN_OFF
                                                                 : gate_quarter;

    always_ff @(posedge i_clk) begin
        if ({1'b0, r_period} > ({1'b0, gate_off} + {1'b0, fss_pkg::GATE_MIN_ON})) begin
            r_gate_hi <= r_period - gate_off;
        end else begin
            r_gate_hi <= fss_pkg::GATE_MIN_ON;
        end
    end

    // ---------------- channels ----------------
    assign move        = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = (r_settle == 2'd0) && (!r_in_valid || move);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.data;
        end
        if (move) begin
            r_out <= n_out;
        end
    end

    // ---------------- step logic ----------------
    assign level_prod   = r_step_level[r_step_index] * r_held_input;
    assign sample_clean = (r_in.sample < fss_pkg::SAMPLE_FLOOR) ? 10'd0 : r_in.sample;

    always_comb begin
        n_step_index    = r_step_index;
        n_level_now     = r_level_now;
        n_gate_open     = r_gate_open;
        n_tick_count    = r_tick_count;
        n_held_input    = r_held_input;
        n_input_was_low = r_input_was_low;
        n_rise_pending  = r_rise_pending;
        n_fall_pending  = r_fall_pending;
        n_mode_external = r_mode_external;
        n_to_int_count  = r_to_int_count;
        n_to_ext_count  = r_to_ext_count;
        n_trigger       = r_trigger;
        tick_base       = r_tick_count;
        n_out.duty_out  = r_level_now;

        if (r_in.opcode == fss_pkg::OP_PWM) begin
            n_level_now = r_gate_open ? level_prod[19:10] : 10'd0;
            if (r_in.sample_valid) begin
                n_held_input = sample_clean;
                if (sample_clean > fss_pkg::RISE_LEVEL) begin
                    if (r_input_was_low) begin
                        n_input_was_low = 1'b0;
                        // a rise that meets a pending fall cancels both
                        if (r_fall_pending) begin
                            n_fall_pending = 1'b0;
                            n_rise_pending = 1'b0;
                        end else begin
                            n_rise_pending = 1'b1;
                        end
                    end
                end else if (sample_clean < fss_pkg::FALL_LEVEL) begin
                    if (!r_input_was_low) begin
                        n_input_was_low = 1'b1;
                        if (r_rise_pending) begin
                            n_rise_pending = 1'b0;
                            n_fall_pending = 1'b0;
                        end else begin
                            n_fall_pending = 1'b1;
                        end
                    end
                end
            end
        end else begin
            if (!r_mode_external) begin
                if (r_held_input >= fss_pkg::RUN_LEVEL) begin
                    if (r_tick_count > r_period) begin
                        n_trigger      = 1'b1;
                        n_gate_open    = 1'b1;
                        n_step_index   = r_step_index + 2'd1;
                        tick_base      = '0;
                        n_rise_pending = 1'b0;
                    end else if (r_tick_count > r_gate_hi) begin
                        n_gate_open = 1'b0;
                        n_trigger   = 1'b0;
                    end
                end
            end else begin
                if (r_rise_pending) begin
                    n_rise_pending = 1'b0;
                    n_trigger      = 1'b1;
                    n_gate_open    = 1'b1;
                    n_step_index   = r_step_index + 2'd1;
                    tick_base      = '0;
                end
                // a fall in the same tick closes the gate just opened
                if (r_fall_pending) begin
                    n_fall_pending = 1'b0;
                    n_gate_open    = 1'b0;
                    n_trigger      = 1'b0;
                end
            end
            n_tick_count = tick_base + 16'd1;

            // mode switch debounce
            if (!r_in.mode_switch_external && r_mode_external) begin
                n_to_ext_count = '0;
                n_to_int_count = r_to_int_count + 2'd1;
                if (n_to_int_count == fss_pkg::DEBOUNCE_TICKS) begin
                    n_mode_external = 1'b0;
                    n_to_int_count  = '0;
                end
            end else if (r_in.mode_switch_external && !r_mode_external) begin
                n_to_int_count = '0;
                n_to_ext_count = r_to_ext_count + 2'd1;
                if (n_to_ext_count == fss_pkg::DEBOUNCE_TICKS) begin
                    n_mode_external = 1'b1;
                    n_to_ext_count  = '0;
                end
            end
        end

        n_out.active_step   = n_step_index;
        n_out.trigger_out   = n_trigger;
        n_out.external_mode = n_mode_external;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_index    <= '0;
            r_level_now     <= '0;
            r_gate_open     <= 1'b0;
            r_tick_count    <= '0;
            r_held_input    <= '0;
            r_input_was_low <= 1'b0;
            r_rise_pending  <= 1'b0;
            r_fall_pending  <= 1'b0;
            r_mode_external <= 1'b0;
            r_to_int_count  <= '0;
            r_to_ext_count  <= '0;
            r_trigger       <= 1'b0;
        end else if (move) begin
            r_step_index    <= n_step_index;
            r_level_now     <= n_level_now;
            r_gate_open     <= n_gate_open;
            r_tick_count    <= n_tick_count;
            r_held_input    <= n_held_input;
            r_input_was_low <= n_input_was_low;
            r_rise_pending  <= n_rise_pending;
            r_fall_pending  <= n_fall_pending;
            r_mode_external <= n_mode_external;
            r_to_int_count  <= n_to_int_count;
            r_to_ext_count  <= n_to_ext_count;
            r_trigger       <= n_trigger;
        end
    end

endmodule

// ===== rtl/fss_checker.sv =====
// port level checks of the four step sequencer and their bind
module fss_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input fss_pkg::t_rsp i_out_data,
    input logic          i_psel,
    input logic          i_penable,
    input logic          i_pwrite,
    input logic [4:0]    i_paddr,
    input logic [31:0]   i_pwdata,
    input logic [31:0]   i_prdata
);

    logic cfg_wr;
    assign cfg_wr = i_psel && i_penable && i_pwrite;

    // reset leaves no result and holds off requests while the curve settles
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && !i_in_ready))
        else $error("result or request ready right after reset");

    // a speed knob write leaves requests stalled right after it while the curve follows
    a_speed_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && i_paddr[4:2] == 3'(fss_pkg::REG_SPEED)) |=> !i_in_ready)
        else $error("request taken before speed curve settled");

    // a register read back right after its write returns the written level
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && i_paddr[4:2] <= 3'(fss_pkg::REG_SPEED))
        ##1 (i_psel && !i_pwrite && i_paddr == $past(i_paddr))
        |-> i_prdata == {22'd0, $past(i_pwdata[9:0])})
        else $error("register read back mismatch");

    // a stalled result holds its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed");

endmodule

bind four_step_sequencer fss_checker u_fss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_data  (o_rsp.data),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata)
);
